// ===== design/tcp_pkg.sv =====
`default_nettype none

package tcp_pkg;

  // Widths of item fields and of configuration data
  localparam int COUNT_W    = 9;
  localparam int ERR_W      = 10;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef logic [2:0] cfg_addr_t;
  localparam cfg_addr_t REG_USE_MATERIAL  = 3'd0;
  localparam cfg_addr_t REG_USE_AO        = 3'd1;
  localparam cfg_addr_t REG_USE_LIGHT_MAP = 3'd2;
  localparam cfg_addr_t REG_AO_RATE       = 3'd3;
  localparam cfg_addr_t REG_LIGHT_GAIN    = 3'd4;
  localparam cfg_addr_t REG_LIGHT_CONST   = 3'd5;

  // Item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Starting distance, above the largest possible sum of 3 * 255
  localparam logic [ERR_W-1:0] ERR_INIT = '1;

  // Configuration register reset values
  localparam logic [8:0]  AO_RATE_RST    = 9'd256;
  localparam logic [15:0] LIGHT_GAIN_RST = 16'd256;

  typedef struct packed {
    logic        use_material;
    logic        use_ao;
    logic        use_light_map;
    logic [8:0]  ao_rate;
    logic [15:0] light_gain;
    logic [7:0]  light_const;
  } cfg_t;

  // One item moving along the cell chain
  typedef struct packed {
    logic               valid;
    logic               cmd;
    logic [7:0]         code;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COUNT_W-1:0] count;      // load: target slot; pixel: entries visible
    logic [ERR_W-1:0]   best_err;
    logic [7:0]         best_code;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
  } token_t;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== design/tcp_if.sv =====
`default_nettype none

// Input channel: load or pixel item
interface tcp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] palette_code;
  logic [7:0] color_red;
  logic [7:0] color_green;
  logic [7:0] color_blue;
  logic [7:0] ao_sample;
  logic [7:0] light_sample;

  modport source(output valid, command, palette_code, color_red, color_green,
                 color_blue, ao_sample, light_sample, input ready);
  modport sink(input valid, command, palette_code, color_red, color_green,
               color_blue, ao_sample, light_sample, output ready);
  modport mon(input valid, ready, command, palette_code, color_red, color_green,
              color_blue, ao_sample, light_sample);
endinterface

// Output channel: packed RGB result
interface tcp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source(output valid, out_red, out_green, out_blue, input ready);
  modport sink(input valid, out_red, out_green, out_blue, output ready);
  modport mon(input valid, ready, out_red, out_green, out_blue);
endinterface

`default_nettype wire

// ===== design/tcp_head.sv =====
`default_nettype none

module tcp_head #(
  parameter int ENTRIES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire tcp_pkg::cfg_t cfg,
  tcp_in_if.sink             in_ch,
  output tcp_pkg::token_t    tok
);
  import tcp_pkg::*;

  logic [COUNT_W-1:0] count;
  logic               full;
  logic               accept;
  logic [8:0]         rate;
  logic [16:0]        ao_prod;
  logic [23:0]        light_prod;
  token_t             tok_next;

  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;
  assign full        = (count == COUNT_W'(ENTRIES));

  // Green and blue channel math
  assign rate       = cfg.ao_rate[8] ? AO_RATE_RST : cfg.ao_rate;
  assign ao_prod    = 17'(8'd255 - in_ch.ao_sample) * 17'(rate);
  assign light_prod = 24'(in_ch.light_sample) * 24'(cfg.light_gain);

  // Build the item that enters the chain
  always_comb begin
    tok_next           = '0;
    tok_next.valid     = accept && !((in_ch.command == CMD_LOAD) && full);
    tok_next.cmd       = in_ch.command;
    tok_next.code      = in_ch.palette_code;
    tok_next.red       = in_ch.color_red;
    tok_next.green     = in_ch.color_green;
    tok_next.blue      = in_ch.color_blue;
    tok_next.count     = count;
    tok_next.best_err  = ERR_INIT;
    tok_next.best_code = 8'd0;
    tok_next.out_green = cfg.use_ao ? (8'd255 - ao_prod[15:8]) : 8'd255;
    if (!cfg.use_light_map) begin
      tok_next.out_blue = cfg.light_const;
    end else if (|light_prod[23:16]) begin
      tok_next.out_blue = 8'd255;
    end else begin
      tok_next.out_blue = light_prod[15:8];
    end
  end

  // Advance the table fill count on loads
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && (in_ch.command == CMD_LOAD) && !full) begin
      count <= count + COUNT_W'(1);
    end
  end

  // Hold the head stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (adv) begin
      tok <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/tcp_cell.sv =====
`default_nettype none

module tcp_cell #(
  parameter int INDEX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire tcp_pkg::token_t tok_in,
  output tcp_pkg::token_t      tok_out
);
  import tcp_pkg::*;

  // Table entry held by this cell
  logic [7:0]       e_code;
  logic [7:0]       e_red;
  logic [7:0]       e_green;
  logic [7:0]       e_blue;
  logic             is_pixel;
  logic             in_use;
  logic [ERR_W-1:0] err;
  token_t           tok_next;

  assign is_pixel = tok_in.valid && (tok_in.cmd == CMD_PIXEL);
  assign in_use   = COUNT_W'(INDEX) < tok_in.count;
  assign err      = ERR_W'(absdiff(tok_in.red, e_red))
                  + ERR_W'(absdiff(tok_in.green, e_green))
                  + ERR_W'(absdiff(tok_in.blue, e_blue));

  // Keep the closer entry; ties keep the earlier one
  always_comb begin
    tok_next = tok_in;
    if (is_pixel && in_use && (err < tok_in.best_err)) begin
      tok_next.best_err  = err;
      tok_next.best_code = e_code;
    end
  end

  // Capture a load addressed to this slot
  always_ff @(posedge clk) begin
    if (adv && tok_in.valid && (tok_in.cmd == CMD_LOAD) &&
        (tok_in.count == COUNT_W'(INDEX))) begin
      e_code  <= tok_in.code;
      e_red   <= tok_in.red;
      e_green <= tok_in.green;
      e_blue  <= tok_in.blue;
    end
  end

  // Hand the item to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/tcp_tail.sv =====
`default_nettype none

module tcp_tail (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tcp_pkg::cfg_t   cfg,
  input  wire tcp_pkg::token_t tok,
  output logic                 adv,
  tcp_out_if.source            out_ch
);
  import tcp_pkg::*;

  logic is_pixel;

  assign is_pixel = tok.valid && (tok.cmd == CMD_PIXEL);
  // Stall the chain only when a pixel would overwrite a waiting result
  assign adv      = !(out_ch.valid && !out_ch.ready && is_pixel);

  // Set, hold or drop the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv && is_pixel) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // Load the result registers
  always_ff @(posedge clk) begin
    if (adv && is_pixel) begin
      out_ch.out_red   <= cfg.use_material ? tok.best_code : 8'd0;
      out_ch.out_green <= tok.out_green;
      out_ch.out_blue  <= tok.out_blue;
    end
  end

endmodule

`default_nettype wire

// ===== design/texture_channel_pack_nearest_palette_top.sv =====
// An accepted pixel item passes the head stage, one cell per table entry and the
// output register before its result is valid.
// Throughput: one item per cycle; loads and pixels stream through the cell chain.
// The chain stalls only while a pixel reaches the end and a result waits untaken.
// Reset: clears the fill count, all stage valids and the output valid, and sets
// the configuration registers to their defaults; table entries are left as is.
`default_nettype none

module texture_channel_pack_nearest_palette_top #(
  parameter int ENTRIES = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_en,
  input  wire tcp_pkg::cfg_addr_t                  cfg_addr,
  input  wire logic [tcp_pkg::CFG_DATA_W-1:0]      cfg_data,
  tcp_in_if.sink                                   in_ch,
  tcp_out_if.source                                out_ch
);
  import tcp_pkg::*;

  cfg_t   cfg;
  logic   adv;
  token_t chain [0:ENTRIES];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_material  <= 1'b0;
      cfg.use_ao        <= 1'b0;
      cfg.use_light_map <= 1'b0;
      cfg.ao_rate       <= AO_RATE_RST;
      cfg.light_gain    <= LIGHT_GAIN_RST;
      cfg.light_const   <= 8'd0;
    end else if (cfg_en) begin
      case (cfg_addr)
        REG_USE_MATERIAL:  cfg.use_material  <= cfg_data[0];
        REG_USE_AO:        cfg.use_ao        <= cfg_data[0];
        REG_USE_LIGHT_MAP: cfg.use_light_map <= cfg_data[0];
        REG_AO_RATE:       cfg.ao_rate       <= cfg_data[8:0];
        REG_LIGHT_GAIN:    cfg.light_gain    <= cfg_data[15:0];
        REG_LIGHT_CONST:   cfg.light_const   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tcp_head #(.ENTRIES(ENTRIES)) u_head (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .cfg   (cfg),
    .in_ch (in_ch),
    .tok   (chain[0])
  );

  // One cell per table entry
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tcp_cell #(.INDEX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  tcp_tail u_tail (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .tok    (chain[ENTRIES]),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== design/tcp_checker.sv =====
`default_nettype none

module tcp_checker (
  input wire logic  clk,
  input wire logic  rst,
  tcp_in_if.sink    in_ch,
  tcp_out_if.source out_ch
);

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid right after reset");

  // Input backpressure only comes from a stalled output
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output backpressure");

  // A waiting result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped while stalled");

  // A waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=>
      ($stable(out_ch.out_red) && $stable(out_ch.out_green) &&
       $stable(out_ch.out_blue)))
    else $error("result changed while stalled");

endmodule

bind texture_channel_pack_nearest_palette_top tcp_checker u_tcp_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
  import tcp_pkg::*;

  localparam int TABLE_DEPTH   = 256;
  localparam int LATENCY       = TABLE_DEPTH + 2;
  localparam int QUIET_LIMIT   = 10 * (LATENCY + 64);
  localparam int MAX_PRINTED   = 40;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 140;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } packed_rgb_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_en;
  cfg_addr_t             cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcp_in_if  in_if ();
  tcp_out_if out_if ();

  texture_channel_pack_nearest_palette_top #(.ENTRIES(TABLE_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_en   (cfg_en),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // Shadow of the block: settings, palette table and fill count
  cfg_t        shadow_cfg;
  logic [7:0]  entry_code  [TABLE_DEPTH];
  logic [7:0]  entry_red   [TABLE_DEPTH];
  logic [7:0]  entry_green [TABLE_DEPTH];
  logic [7:0]  entry_blue  [TABLE_DEPTH];
  int unsigned entry_fill;

  packed_rgb_t expected_pixels[$];

  int   error_count = 0;
  int   printed = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;
  int   steady_left = 0;
  logic no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (printed < MAX_PRINTED) begin
      printed++;
      $display("ERROR @%0t: %s", $realtime, what);
    end
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_channel();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] v, input logic jitter);
    int x;
    x = int'(v);
    if (jitter) x = x + int'($urandom_range(0, 6)) - 3;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return 8'(x);
  endfunction

  // Expected packed RGB for one pixel against the current table and settings
  function automatic packed_rgb_t predict_pixel(input logic [7:0] r, g, b, ao, light);
    packed_rgb_t res;
    int unsigned l1_err;
    int unsigned best_dist;
    int unsigned rate;
    int unsigned scaled;
    logic        found;
    res = '0;
    found = 1'b0;
    best_dist = 0;
    // Nearest entry by L1 distance; the earliest entry keeps a tie
    if (shadow_cfg.use_material) begin
      for (int i = 0; i < entry_fill; i++) begin
        l1_err = (r >= entry_red[i]   ? r - entry_red[i]   : entry_red[i]   - r)
               + (g >= entry_green[i] ? g - entry_green[i] : entry_green[i] - g)
               + (b >= entry_blue[i]  ? b - entry_blue[i]  : entry_blue[i]  - b);
        if (!found || l1_err < best_dist) begin
          found = 1'b1;
          best_dist = l1_err;
          res.red = entry_code[i];
        end
      end
    end
    // Blend AO toward white; rates above full weight clamp to full weight
    if (shadow_cfg.use_ao) begin
      rate = (shadow_cfg.ao_rate > 9'd256) ? 256 : shadow_cfg.ao_rate;
      scaled = ((255 - ao) * rate) >> 8;
      res.green = 8'(255 - scaled);
    end else begin
      res.green = 8'd255;
    end
    // Scale light sample and saturate
    if (shadow_cfg.use_light_map) begin
      scaled = (light * shadow_cfg.light_gain) >> 8;
      res.blue = (scaled > 255) ? 8'd255 : 8'(scaled);
    end else begin
      res.blue = shadow_cfg.light_const;
    end
    return res;
  endfunction

  // Input side: append loads to the table, queue predictions for pixels
  always @(posedge clk) begin
    if (!rst && in_if.valid && in_if.ready) begin
      if (in_if.command == CMD_PIXEL) begin
        expected_pixels.push_back(predict_pixel(in_if.color_red, in_if.color_green,
                                                in_if.color_blue, in_if.ao_sample,
                                                in_if.light_sample));
      end else if (entry_fill < TABLE_DEPTH) begin
        entry_code[entry_fill]  = in_if.palette_code;
        entry_red[entry_fill]   = in_if.color_red;
        entry_green[entry_fill] = in_if.color_green;
        entry_blue[entry_fill]  = in_if.color_blue;
        entry_fill++;
      end
    end
  end

  // Output side: compare each result with the oldest prediction
  always @(posedge clk) begin
    packed_rgb_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no pixel item pending");
      end else begin
        want = expected_pixels.pop_front();
        if (out_if.out_red !== want.red)
          report_mismatch($sformatf("out_red got %0d want %0d", out_if.out_red, want.red));
        if (out_if.out_green !== want.green)
          report_mismatch($sformatf("out_green got %0d want %0d",
                                    out_if.out_green, want.green));
        if (out_if.out_blue !== want.blue)
          report_mismatch($sformatf("out_blue got %0d want %0d",
                                    out_if.out_blue, want.blue));
      end
    end
  end

  // Receiver: random stalls with calm stretches in between
  always @(posedge clk) begin
    int roll;
    if (rst) begin
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if (steady_left > 0) begin
        steady_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 4) steady_left = $urandom_range(100, 400);
        else if (roll < 30) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] code, r, g, b, ao, light);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.palette_code <= code;
    in_if.color_red    <= r;
    in_if.color_green  <= g;
    in_if.color_blue   <= b;
    in_if.ao_sample    <= ao;
    in_if.light_sample <= light;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  // Drain, then let trailing loads clear the chain
  task automatic wait_idle();
    wait_results();
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Write one register; bits above its width carry junk
  task automatic write_register(input cfg_addr_t addr, input int unsigned value,
                                input int unsigned width);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] data;
    mask = (width >= CFG_DATA_W) ? '1 : CFG_DATA_W'((1 << width) - 1);
    data = CFG_DATA_W'($urandom_range(0, 65535));
    data = (data & ~mask) | (CFG_DATA_W'(value) & mask);
    cfg_en   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    case (addr)
      REG_USE_MATERIAL:  shadow_cfg.use_material  = data[0];
      REG_USE_AO:        shadow_cfg.use_ao        = data[0];
      REG_USE_LIGHT_MAP: shadow_cfg.use_light_map = data[0];
      REG_AO_RATE:       shadow_cfg.ao_rate       = data[8:0];
      REG_LIGHT_GAIN:    shadow_cfg.light_gain    = data[15:0];
      REG_LIGHT_CONST:   shadow_cfg.light_const   = data[7:0];
      default: ;
    endcase
  endtask

  task automatic program_settings(input cfg_t s);
    write_register(REG_USE_MATERIAL, s.use_material, 1);
    write_register(REG_USE_AO, s.use_ao, 1);
    write_register(REG_USE_LIGHT_MAP, s.use_light_map, 1);
    write_register(REG_AO_RATE, s.ao_rate, 9);
    write_register(REG_LIGHT_GAIN, s.light_gain, 16);
    write_register(REG_LIGHT_CONST, s.light_const, 8);
    cfg_en <= 1'b0;
  endtask

  // Colour: random, a copy of a stored entry, or close to one
  task automatic pick_colour(output logic [7:0] r, g, b);
    int unsigned mode;
    int unsigned k;
    mode = $urandom_range(0, 99);
    if (entry_fill == 0 || mode < 50) begin
      r = rand_channel();
      g = rand_channel();
      b = rand_channel();
    end else begin
      k = $urandom_range(0, entry_fill - 1);
      r = nudge(entry_red[k], mode >= 75);
      g = nudge(entry_green[k], mode >= 75);
      b = nudge(entry_blue[k], mode >= 75);
    end
  endtask

  // Reset settings: red 0, green white, blue zero
  task automatic test_reset_defaults();
    send_item(CMD_PIXEL, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    send_item(CMD_PIXEL, 8'h00, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
    send_item(CMD_PIXEL, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h96, 8'h69);
  endtask

  // Material lookup with nothing loaded gives code 0
  task automatic test_empty_table();
    wait_idle();
    program_settings(cfg_t'{1'b1, 1'b1, 1'b1, 9'd256, 16'd256, 8'd255});
    send_item(CMD_PIXEL, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    send_item(CMD_PIXEL, 8'h00, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128);
  endtask

  // Exact hits, duplicate colours and equal distances to different colours
  task automatic test_nearest_ties();
    send_item(CMD_LOAD, 8'hA5, 8'd0, 8'd0, 8'd0, 8'h55, 8'hAA);
    send_item(CMD_LOAD, 8'h5A, 8'd255, 8'd255, 8'd255, 8'hAA, 8'h55);
    send_item(CMD_LOAD, 8'h11, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255);
    send_item(CMD_LOAD, 8'h22, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0);
    send_item(CMD_LOAD, 8'hFF, 8'd10, 8'd0, 8'd0, 8'd1, 8'd2);
    send_item(CMD_LOAD, 8'h00, 8'd0, 8'd10, 8'd0, 8'd3, 8'd4);
    send_item(CMD_PIXEL, 8'h00, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128);
    send_item(CMD_PIXEL, 8'h00, 8'd255, 8'd255, 8'd255, 8'd64, 8'd200);
    send_item(CMD_PIXEL, 8'h00, 8'd128, 8'd128, 8'd128, 8'd1, 8'd254);
    send_item(CMD_PIXEL, 8'h00, 8'd5, 8'd5, 8'd0, 8'd254, 8'd1);
    send_item(CMD_PIXEL, 8'h00, 8'd200, 8'd10, 8'd90, 8'd77, 8'd33);
  endtask

  // Rate and constant extremes on each channel
  task automatic test_channel_rates();
    cfg_t settings[4];
    settings[0] = cfg_t'{1'b1, 1'b1, 1'b1, 9'd0, 16'hFFFF, 8'd0};
    settings[1] = cfg_t'{1'b0, 1'b1, 1'b1, 9'd511, 16'd0, 8'd255};
    settings[2] = cfg_t'{1'b1, 1'b1, 1'b0, 9'd257, 16'd1, 8'd170};
    settings[3] = cfg_t'{1'b1, 1'b0, 1'b1, 9'd1, 16'd255, 8'd85};
    foreach (settings[s]) begin
      wait_idle();
      program_settings(settings[s]);
      send_item(CMD_PIXEL, 8'h00, 8'd5, 8'd5, 8'd0, 8'd0, 8'd255);
      send_item(CMD_PIXEL, 8'hFF, 8'd255, 8'd0, 8'd255, 8'd255, 8'd1);
    end
  endtask

  // Random phases: mixed loads and pixels, filling the table past its end
  task automatic test_random_stream();
    cfg_t        s;
    int unsigned load_pct;
    logic [7:0]  r, g, b;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      s.use_material  = ($urandom_range(0, 9) < 8);
      s.use_ao        = 1'($urandom_range(0, 1));
      s.use_light_map = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       s.ao_rate = 9'd0;
        1:       s.ao_rate = 9'd256;
        2:       s.ao_rate = 9'($urandom_range(257, 511));
        default: s.ao_rate = 9'($urandom_range(0, 256));
      endcase
      case ($urandom_range(0, 5))
        0:       s.light_gain = 16'd0;
        1:       s.light_gain = 16'hFFFF;
        2:       s.light_gain = 16'd256;
        default: s.light_gain = 16'($urandom_range(0, 65535));
      endcase
      s.light_const = rand_channel();
      program_settings(s);
      load_pct = (phase < 4) ? 35 : 20;
      no_gaps = (phase % 2 == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 40) no_gaps = 1'b0;
        // Hold the sender once until every result is back
        if (phase == 5 && n == 70) wait_results();
        pick_colour(r, g, b);
        if ($urandom_range(0, 99) < load_pct)
          send_item(CMD_LOAD, 8'($urandom_range(0, 255)), r, g, b,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else
          send_item(CMD_PIXEL, 8'($urandom_range(0, 255)), r, g, b,
                    rand_channel(), rand_channel());
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_en             <= 1'b0;
    cfg_addr           <= REG_USE_MATERIAL;
    cfg_data           <= '0;
    in_if.valid        <= 1'b0;
    in_if.command      <= CMD_LOAD;
    in_if.palette_code <= 8'd0;
    in_if.color_red    <= 8'd0;
    in_if.color_green  <= 8'd0;
    in_if.color_blue   <= 8'd0;
    in_if.ao_sample    <= 8'd0;
    in_if.light_sample <= 8'd0;
    no_gaps = 1'b0;
    entry_fill = 0;
    shadow_cfg = cfg_t'{1'b0, 1'b0, 1'b0, AO_RATE_RST, LIGHT_GAIN_RST, 8'd0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_empty_table();
    test_nearest_ties();
    test_channel_rates();
    test_random_stream();

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== texture_channel_pack_nearest_palette_top.f =====
design/tcp_pkg.sv
design/tcp_if.sv
design/tcp_head.sv
design/tcp_cell.sv
design/tcp_tail.sv
design/texture_channel_pack_nearest_palette_top.sv
design/tcp_checker.sv
tb/sv/tb.sv
